// ===== hw/rtl/dild_pkg.sv =====
// ----------------------------------------------------------------------------
// dild_pkg
// Types and constants shared by the discrete input lockout debouncer.
// ----------------------------------------------------------------------------
package dild_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int CHECK_W     = 8;
    localparam int HOLD_W      = 16;
    localparam int SKIP_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_BYTE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLASH_SKIP  = 2'd2;

    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET  = 16'd10;
    localparam logic [CHECK_W-1:0] CHECK_BYTE_RESET  = 8'b1010_1010;
    localparam logic [SKIP_W-1:0]  FLASH_SKIP_RESET  = 8'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_bits;
        logic [CHECK_W-1:0]  echo_byte;
        logic                thermal_fault;
        logic                supply_missing;
        logic                flash_busy;
    } poll_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] channel_levels;
        logic [SAMPLE_W-1:0] changed_mask;
        logic [STATUS_W-1:0] status_bits;
        logic                status_changed;
        logic                poll_used;
    } result_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_ticks;
        logic [CHECK_W-1:0] expected_check_byte;
        logic [SKIP_W-1:0]  flash_skip_polls;
    } cfg_regs_t;

endpackage

// ===== hw/rtl/dild_core.sv =====
// ----------------------------------------------------------------------------
// dild_core
// Channel state, hold counters, status and flash skip logic for one poll.
// ----------------------------------------------------------------------------
module dild_core
    import dild_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  poll_t     poll,
    input  cfg_regs_t cfg,
    output result_t   result
);

    localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [CHANNELS-1:0]    level_reg;
    logic [CHANNELS-1:0]    level_next;
    logic [CHANNELS-1:0]    lock_reg;
    logic [CHANNELS-1:0]    lock_next;
    logic [COUNT_WIDTH-1:0] count_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] count_next [CHANNELS];
    logic [COUNT_WIDTH-1:0] count_adv  [CHANNELS];
    logic [STATUS_W-1:0]    last_status_reg;
    logic [STATUS_W-1:0]    last_status_next;
    logic                   first_done_reg;
    logic [SKIP_W-1:0]      skip_reg;
    logic [SKIP_W-1:0]      skip_next;
    logic [STATUS_W-1:0]    status;
    logic [CHANNELS-1:0]    samples;
    logic                   used;

    always_comb
    begin
        status  = {poll.echo_byte != cfg.expected_check_byte,
                   poll.supply_missing, poll.thermal_fault};
        samples = CHANNELS'(poll.sample_bits);
        used    = first_done_reg && (status == '0) && !poll.flash_busy && (skip_reg == '0);

        last_status_next = last_status_reg;
        skip_next        = skip_reg;
        if (first_done_reg)
        begin
            last_status_next = status;
            if (status == '0)
            begin
                if (poll.flash_busy)
                    skip_next = cfg.flash_skip_polls;
                else if (skip_reg != '0)
                    skip_next = skip_reg - 1'b1;
            end
        end

        level_next = level_reg;
        lock_next  = lock_reg;
        for (int k = 0; k < CHANNELS; k++)
        begin
            count_adv[k] = (lock_reg[k] && count_reg[k] != COUNT_MAX) ?
                           count_reg[k] + 1'b1 : count_reg[k];
            count_next[k] = count_adv[k];
            if (used)
            begin
                if (!lock_reg[k])
                begin
                    if (samples[k] != level_reg[k])
                    begin
                        level_next[k] = samples[k];
                        lock_next[k]  = 1'b1;
                    end
                end
                else if (CMP_W'(count_adv[k]) >= CMP_W'(cfg.hold_ticks))
                begin
                    count_next[k] = '0;
                    lock_next[k]  = 1'b0;
                end
            end
        end

        result.channel_levels = SAMPLE_W'(level_next);
        result.changed_mask   = SAMPLE_W'(level_next ^ level_reg);
        result.status_bits    = status;
        result.status_changed = first_done_reg && (status != last_status_reg);
        result.poll_used      = used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            lock_reg        <= '0;
            last_status_reg <= '0;
            first_done_reg  <= 1'b0;
            skip_reg        <= '0;
            for (int k = 0; k < CHANNELS; k++)
                count_reg[k] <= '0;
        end
        else if (fire)
        begin
            level_reg       <= level_next;
            lock_reg        <= lock_next;
            last_status_reg <= last_status_next;
            first_done_reg  <= 1'b1;
            skip_reg        <= skip_next;
            for (int k = 0; k < CHANNELS; k++)
                count_reg[k] <= count_next[k];
        end
    end

endmodule

// ===== hw/rtl/discrete_input_lockout_debouncer.sv =====
// ----------------------------------------------------------------------------
// discrete_input_lockout_debouncer
// Path: each poll word is registered at the input, its result word at the output.
// Throughput: one poll word per cycle unless the receiver stalls the result; the input
// and result registers each hold one word, and the channel state updates once per word.
// Reset: all channel levels, lockouts, counters and the skip count clear;
// configuration returns to hold 10, check byte 0xAA, flash skip 3.
// ----------------------------------------------------------------------------
module discrete_input_lockout_debouncer
    import dild_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   poll_valid,
    output logic                   poll_ready,
    input  poll_t                  poll,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_regs_t cfg_reg;
    logic      in_valid_reg;
    poll_t     in_word_reg;
    logic      out_valid_reg;
    result_t   out_word_reg;
    result_t   core_result;
    logic      advance;
    logic      fire;

    assign advance    = !out_valid_reg || result_ready;
    assign fire       = in_valid_reg && advance;
    assign poll_ready = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks          <= HOLD_TICKS_RESET;
            cfg_reg.expected_check_byte <= CHECK_BYTE_RESET;
            cfg_reg.flash_skip_polls    <= FLASH_SKIP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD_TICKS: cfg_reg.hold_ticks          <= cfg_data;
                REG_CHECK_BYTE: cfg_reg.expected_check_byte <= cfg_data[CHECK_W-1:0];
                REG_FLASH_SKIP: cfg_reg.flash_skip_polls    <= cfg_data[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll_ready)
                in_valid_reg <= poll_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
            in_word_reg <= poll;
        if (fire)
            out_word_reg <= core_result;
    end

    dild_core #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .poll   (in_word_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("input stage lost a stalled word");

    a_used_needs_clear_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.poll_used |-> out_word_reg.status_bits == '0)
        else $error("channel update while status set");

    a_change_needs_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.changed_mask != '0 |-> out_word_reg.poll_used)
        else $error("level change on an unused poll");

    a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("result register not loaded");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the discrete input lockout debouncer. Poll words are
// driven over valid/ready with random gaps, and each one runs through a
// per-poll debounce model: lockout counters, the status block, the first
// ignored poll, and the flash skip. Result words are compared field by field
// in order. Covers register extremes, receiver back-pressure and long lockouts
// with counters advancing under faults.
// ----------------------------------------------------------------------------
module tb;
    import dild_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int NCH = 8;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   poll_valid;
    logic                   poll_ready;
    poll_t                  poll_word;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result_word;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    discrete_input_lockout_debouncer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // debounce state and registers
    logic [HOLD_W-1:0]   hold_ticks_r  = HOLD_TICKS_RESET;
    logic [CHECK_W-1:0]  check_byte_r  = CHECK_BYTE_RESET;
    logic [SKIP_W-1:0]   skip_polls_r  = FLASH_SKIP_RESET;
    logic [NCH-1:0]      acc_level     = '0;
    logic [NCH-1:0]      locked        = '0;
    logic [HOLD_W-1:0]   lock_cnt [NCH];
    logic [STATUS_W-1:0] prev_status   = '0;
    bit                  first_seen    = 1'b0;
    logic [SKIP_W-1:0]   skip_left     = '0;

    result_t debounced_q [$];

    bit               idle_on       = 1'b1;
    int               hold_off_req  = 0;
    int               hold_off_left = 0;
    int               stall_left    = 0;
    logic [NCH-1:0]   drift_sample  = '0;
    int               errors        = 0;
    int               polls_sent    = 0;
    int               words_checked = 0;
    int               settings_run  = 0;

    initial begin
        for (int k = 0; k < NCH; k++)
            lock_cnt[k] = '0;
    end

    function automatic result_t debounce_poll(input poll_t p);
        result_t             r;
        logic [NCH-1:0]      prior;
        logic [STATUS_W-1:0] st;
        bit                  used;
        bit                  st_chg;
        for (int k = 0; k < NCH; k++)
            if (locked[k] && lock_cnt[k] != '1)
                lock_cnt[k] = lock_cnt[k] + 1'b1;
        st = {p.echo_byte != check_byte_r, p.supply_missing, p.thermal_fault};
        prior = acc_level;
        used = 1'b0;
        st_chg = 1'b0;
        if (!first_seen) begin
            first_seen = 1'b1;
        end
        else begin
            st_chg = (st != prev_status);
            prev_status = st;
            if (st == '0) begin
                if (p.flash_busy) begin
                    skip_left = skip_polls_r;
                end
                else if (skip_left != '0) begin
                    skip_left = skip_left - 1'b1;
                end
                else begin
                    used = 1'b1;
                    for (int k = 0; k < NCH; k++) begin
                        if (!locked[k]) begin
                            if (p.sample_bits[k] != acc_level[k]) begin
                                acc_level[k] = p.sample_bits[k];
                                locked[k] = 1'b1;
                            end
                        end
                        else if (lock_cnt[k] >= hold_ticks_r) begin
                            lock_cnt[k] = '0;
                            locked[k] = 1'b0;
                        end
                    end
                end
            end
        end
        r.channel_levels = acc_level;
        r.changed_mask   = prior ^ acc_level;
        r.status_bits    = st;
        r.status_changed = st_chg;
        r.poll_used      = used;
        return r;
    endfunction

    function automatic poll_t mk_poll(input logic [7:0] s, input logic [7:0] e,
                                      input bit th, input bit su, input bit fl);
        poll_t p;
        p.sample_bits    = s;
        p.echo_byte      = e;
        p.thermal_fault  = th;
        p.supply_missing = su;
        p.flash_busy     = fl;
        return p;
    endfunction

    // mostly slow-moving inputs with a good echo; faults and flash are rare
    function automatic poll_t random_poll();
        poll_t p;
        if ($urandom_range(0, 99) < 15)
            p.sample_bits = 8'($urandom);
        else if ($urandom_range(0, 3) == 0)
            p.sample_bits = drift_sample ^ 8'(1 << $urandom_range(0, 7));
        else
            p.sample_bits = drift_sample;
        drift_sample = p.sample_bits;
        p.echo_byte      = ($urandom_range(0, 19) == 0) ? 8'($urandom) : check_byte_r;
        p.thermal_fault  = ($urandom_range(0, 24) == 0);
        p.supply_missing = ($urandom_range(0, 24) == 0);
        p.flash_busy     = ($urandom_range(0, 29) == 0);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 50)
            $display("ERROR word %0d %s: got %0h want %0h", words_checked, what, got, want);
    endtask

    task automatic send_poll(input poll_t p);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0) begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll_word <= p;
        @(posedge clk);
        while (!poll_ready)
            @(posedge clk);
        debounced_q.push_back(debounce_poll(p));
        polls_sent++;
    endtask

    task automatic drain();
        poll_valid <= 1'b0;
        do
            @(posedge clk);
        while (debounced_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_HOLD_TICKS: hold_ticks_r = val;
            REG_CHECK_BYTE: check_byte_r = val[CHECK_W-1:0];
            REG_FLASH_SKIP: skip_polls_r = val[SKIP_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] hold, input logic [7:0] chk,
                            input logic [7:0] skip);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_CHECK_BYTE, {8'h00, chk});
        write_reg(REG_FLASH_SKIP, {8'h00, skip});
        settings_run++;
    endtask

    // receiver: long hold-off on request, otherwise random stall bursts
    always @(posedge clk) begin
        if (hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            result_ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_words
        result_t want;
        if (rst_n && result_valid && result_ready) begin
            if (debounced_q.size() == 0) begin
                report_mismatch("word with nothing pending", result_word, 0);
            end
            else begin
                want = debounced_q.pop_front();
                if (result_word.channel_levels !== want.channel_levels)
                    report_mismatch("channel_levels", result_word.channel_levels,
                                    want.channel_levels);
                if (result_word.changed_mask !== want.changed_mask)
                    report_mismatch("changed_mask", result_word.changed_mask,
                                    want.changed_mask);
                if (result_word.status_bits !== want.status_bits)
                    report_mismatch("status_bits", result_word.status_bits,
                                    want.status_bits);
                if (result_word.status_changed !== want.status_changed)
                    report_mismatch("status_changed", result_word.status_changed,
                                    want.status_changed);
                if (result_word.poll_used !== want.poll_used)
                    report_mismatch("poll_used", result_word.poll_used, want.poll_used);
            end
            words_checked++;
        end
    end

    task automatic test_directed();
        send_poll(mk_poll(8'hFF, 8'h00, 1, 1, 1));   // first poll is ignored
        send_poll(mk_poll(8'hFF, 8'hAA, 0, 0, 0));
        send_poll(mk_poll(8'h00, 8'hAA, 1, 0, 0));
        send_poll(mk_poll(8'h00, 8'hAA, 0, 1, 0));
        send_poll(mk_poll(8'h00, 8'h55, 0, 0, 0));
        send_poll(mk_poll(8'h00, 8'hAA, 1, 1, 1));   // flash ignored under fault
        send_poll(mk_poll(8'h00, 8'hAA, 0, 0, 1));
        repeat (3)
            send_poll(mk_poll(8'h00, 8'hAA, 0, 0, 0));
        send_poll(mk_poll(8'h00, 8'hAA, 0, 0, 0));
        send_poll(mk_poll(8'h00, 8'hAA, 0, 0, 0));   // release, input not looked at
        send_poll(mk_poll(8'h00, 8'hAA, 0, 0, 0));
        send_poll(mk_poll(8'h0F, 8'hAA, 0, 0, 0));
        send_poll(mk_poll(8'h00, 8'hFF, 0, 0, 1));
        send_poll(mk_poll(8'h00, 8'h00, 0, 0, 0));
        send_poll(mk_poll(8'hA5, 8'hAA, 0, 0, 0));
        send_poll(mk_poll(8'h5A, 8'hAA, 0, 0, 0));
        repeat (6)
            send_poll(mk_poll(8'h3C, 8'hAA, 0, 0, 0));
        drain();
    endtask

    task automatic test_register_extremes();
        set_regs(16'h0000, 8'h00, 8'h00);
        repeat (80) send_poll(random_poll());
        drain();
        set_regs(16'hFFFF, 8'hFF, 8'hFF);
        repeat (80) send_poll(random_poll());
        drain();
        set_regs(16'h0001, 8'h5A, 8'h01);
        write_reg(REG_UNUSED, 16'hFFFF);
        repeat (80) send_poll(random_poll());
        drain();
    endtask

    task automatic test_backpressure();
        set_regs(16'd3, 8'hAA, 8'd2);
        hold_off_req = 150;
        repeat (40) send_poll(random_poll());
        drain();
        repeat (40) send_poll(random_poll());
        drain();
    endtask

    // every channel locked with the longest hold, then faulted polls advance the counters
    task automatic test_long_hold();
        idle_on = 1'b0;
        set_regs(16'hFFFF, 8'hAA, 8'd0);
        send_poll(mk_poll(8'h00, 8'hAA, 0, 0, 1));
        send_poll(mk_poll(~acc_level, 8'hAA, 0, 0, 0));
        repeat (60)
            send_poll(mk_poll(8'($urandom), 8'($urandom), 1, 1'($urandom), 1'($urandom)));
        repeat (4)
            send_poll(mk_poll(8'($urandom), 8'hAA, 0, 0, 0));
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                idle_on = 1'b0;
            set_regs(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24)),
                     8'($urandom), 8'($urandom_range(0, 6)));
            repeat (100) send_poll(random_poll());
            drain();
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        poll_valid <= 1'b0;
        poll_word <= '0;
        result_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_long_hold();
        test_random();

        $display("Checked %0d result words from %0d polls over %0d register settings.",
                 words_checked, polls_sent, settings_run);
        $display("Covered fault blocking, flash skip, lockout release, stalls, long holds.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d words outstanding", debounced_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dild_pkg.sv
hw/rtl/dild_core.sv
hw/rtl/discrete_input_lockout_debouncer.sv
test/tb.sv
